// ===== rtl/bts_pkg.sv =====
// Package for the buzzer tone sequencer: item types, codes, register defaults and tone table.
package bts_pkg;

  // Default build values
  localparam int NOTE_COUNT_DEF  = 37;
  localparam int COUNT_WIDTH_DEF = 16;

  // Entries actually held in the tone table
  localparam int TONE_ENTRIES = 37;

  // Command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_NOTE = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_MS_PER_SIXTEENTH = 2'd0;
  localparam logic [1:0] REG_TICKS_PER_MS     = 2'd1;
  localparam logic [1:0] REG_GAP_MS           = 2'd2;

  // Register reset values
  localparam logic [9:0]  MS_PER_SIXTEENTH_RST = 10'd75;
  localparam logic [15:0] TICKS_PER_MS_RST     = 16'd1000;
  localparam logic [7:0]  GAP_MS_RST           = 8'd5;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_NOTE = 2'd1,
    PH_GAP  = 2'd2,
    PH_STOP = 2'd3
  } phase_e;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] note_index;
    logic [7:0] note_length;
  } in_item_t;

  typedef struct packed {
    logic buzzer_level;
    logic busy_res;
    logic note_done;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] wdata;
  } cfg_wr_t;

  // Current register contents, handed to the core
  typedef struct packed {
    logic [9:0]  ms_per_sixteenth;
    logic [15:0] ticks_per_ms;
    logic [7:0]  gap_ms;
  } cfg_t;

  // Reload value per note; index 0 and anything past the table is a rest
  function automatic logic [15:0] tone_reload(input logic [5:0] idx);
    logic [15:0] r;
    case (idx)
      6'd1:  r = 16'd63628;
      6'd2:  r = 16'd63731;
      6'd3:  r = 16'd63835;
      6'd4:  r = 16'd63928;
      6'd5:  r = 16'd64021;
      6'd6:  r = 16'd64103;
      6'd7:  r = 16'd64185;
      6'd8:  r = 16'd64260;
      6'd9:  r = 16'd64331;
      6'd10: r = 16'd64400;
      6'd11: r = 16'd64463;
      6'd12: r = 16'd64528;
      6'd13: r = 16'd64580;
      6'd14: r = 16'd64633;
      6'd15: r = 16'd64684;
      6'd16: r = 16'd64732;
      6'd17: r = 16'd64777;
      6'd18: r = 16'd64820;
      6'd19: r = 16'd64860;
      6'd20: r = 16'd64898;
      6'd21: r = 16'd64934;
      6'd22: r = 16'd64968;
      6'd23: r = 16'd65000;
      6'd24: r = 16'd65030;
      6'd25: r = 16'd65058;
      6'd26: r = 16'd65085;
      6'd27: r = 16'd65110;
      6'd28: r = 16'd65134;
      6'd29: r = 16'd65157;
      6'd30: r = 16'd65178;
      6'd31: r = 16'd65198;
      6'd32: r = 16'd65217;
      6'd33: r = 16'd65235;
      6'd34: r = 16'd65252;
      6'd35: r = 16'd65268;
      6'd36: r = 16'd65283;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/bts_stream_if.sv =====
// Valid/ready channel carrying one item of a given payload type.
interface bts_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bts_cfg_regs.sv =====
// Configuration register file of the buzzer tone sequencer.
module bts_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  bts_pkg::cfg_wr_t wr_i,
  output bts_pkg::cfg_t   cfg_o
);
  import bts_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register index; writes past the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_i.index)
        REG_MS_PER_SIXTEENTH: cfg_d.ms_per_sixteenth = wr_i.wdata[9:0];
        REG_TICKS_PER_MS:     cfg_d.ticks_per_ms     = wr_i.wdata;
        REG_GAP_MS:           cfg_d.gap_ms           = wr_i.wdata[7:0];
        default:              cfg_d                  = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ms_per_sixteenth <= MS_PER_SIXTEENTH_RST;
      cfg_q.ticks_per_ms     <= TICKS_PER_MS_RST;
      cfg_q.gap_ms           <= GAP_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

// ===== rtl/bts_tone_core.sv =====
// Tone timer, note timer and play phase: one step per executed item.
module bts_tone_core #(
  parameter int NOTE_COUNT  = bts_pkg::NOTE_COUNT_DEF,
  parameter int COUNT_WIDTH = bts_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  bts_pkg::in_item_t  item_i,
  input  bts_pkg::cfg_t      cfg_i,
  output bts_pkg::out_item_t result_o
);
  import bts_pkg::*;

  logic [COUNT_WIDTH-1:0] tone_q, tone_d;
  logic                   buzz_q, buzz_d;
  logic [5:0]             note_q, note_d;
  logic [15:0]            pre_q, pre_d;
  logic [17:0]            ms_q, ms_d;
  phase_e                 phase_q, phase_d;
  logic                   done;

  logic [31:0]            reload_wide;
  logic [COUNT_WIDTH-1:0] reload;
  logic [17:0]            note_ms;

  // Reload value for the note in play; out-of-range indexes rest
  always_comb begin
    reload_wide = {16'd0, tone_reload(note_q)};
    if ({1'b0, note_q} >= 7'(NOTE_COUNT) || {1'b0, note_q} >= 7'(TONE_ENTRIES)) begin
      reload = '0;
    end else begin
      reload = reload_wide[COUNT_WIDTH-1:0];
    end
  end

  // 8 x 10 bit product, at most 260865, fits in 18 bits
  assign note_ms = 18'(item_i.note_length) * 18'(cfg_i.ms_per_sixteenth);

  // Next state for one item
  always_comb begin
    tone_d  = tone_q;
    buzz_d  = buzz_q;
    note_d  = note_q;
    pre_d   = pre_q;
    ms_d    = ms_q;
    phase_d = phase_q;
    done    = 1'b0;
    case (item_i.command)
      CMD_TICK: begin
        // Tone counter runs in idle and during a note
        if (phase_q == PH_IDLE || phase_q == PH_NOTE) begin
          if (tone_q == '1) begin
            if (reload != '0) begin
              tone_d = reload;
              buzz_d = ~buzz_q;
            end else begin
              tone_d = '0;
            end
          end else begin
            tone_d = tone_q + 1'b1;
          end
        end
        // Millisecond timing of note and gap
        if (phase_q == PH_NOTE || phase_q == PH_GAP) begin
          if (ms_q != '0) begin
            pre_d = pre_q + 16'd1;
            if (pre_d >= cfg_i.ticks_per_ms) begin
              pre_d = '0;
              ms_d  = ms_q - 18'd1;
            end
          end
          if (ms_d == '0) begin
            pre_d = '0;
            if (phase_q == PH_NOTE) begin
              phase_d = PH_GAP;
              ms_d    = {10'd0, cfg_i.gap_ms};
            end else begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
          end
        end
      end
      CMD_NOTE: begin
        note_d  = item_i.note_index;
        ms_d    = note_ms;
        pre_d   = '0;
        phase_d = PH_NOTE;
      end
      CMD_STOP: begin
        phase_d = PH_STOP;
        ms_d    = '0;
        pre_d   = '0;
      end
      default: begin
        // unknown command: no change
      end
    endcase
  end

  assign result_o.buzzer_level = buzz_d;
  assign result_o.busy_res     = (phase_d == PH_NOTE) || (phase_d == PH_GAP);
  assign result_o.note_done    = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_q  <= '0;
      buzz_q  <= 1'b1;
      note_q  <= '0;
      pre_q   <= '0;
      ms_q    <= '0;
      phase_q <= PH_IDLE;
    end else if (step_i) begin
      tone_q  <= tone_d;
      buzz_q  <= buzz_d;
      note_q  <= note_d;
      pre_q   <= pre_d;
      ms_q    <= ms_d;
      phase_q <= phase_d;
    end
  end
endmodule

// ===== rtl/buzzer_tone_sequencer.sv =====
// Top level of the buzzer tone sequencer: input register, core, result register.
//
//   channel  direction  payload                                  accepted when
//   in_i     sink       command, note_index, note_length         valid && ready
//   out_o    source     buzzer_level, busy_res, note_done        valid && ready
//   cfg_i    sink       index, wdata (register write)            valid && ready
//
// One item per cycle while out_o is ready; each item passes input register -> core ->
// result register, and out_o presents its result from the result register.
// The core state update for one item is combinational and registered when the core steps.
// Reset clears both registers and loads the documented register and timer values.
// A stalled result holds the core; the input register still takes one more item.
// Configuration writes are always accepted and take effect once registered.
module buzzer_tone_sequencer #(
  parameter int NOTE_COUNT  = bts_pkg::NOTE_COUNT_DEF,
  parameter int COUNT_WIDTH = bts_pkg::COUNT_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bts_stream_if.sink    in_i,
  bts_stream_if.source  out_o,
  bts_stream_if.sink    cfg_i
);
  import bts_pkg::*;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t result;
  cfg_t      cfg;
  logic      step;

  // Core steps when an item waits and the result slot is free or draining
  assign step        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || step;
  assign cfg_i.ready = 1'b1;

  bts_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_i.valid),
    .wr_i    (cfg_i.data),
    .cfg_o   (cfg)
  );

  bts_tone_core #(
    .NOTE_COUNT  (NOTE_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= in_i.data;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;
endmodule

// ===== rtl/bts_checker.sv =====
// Port-level checks for the buzzer tone sequencer, bound to the top level.
module bts_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input bts_pkg::out_item_t out_data_i
);
  import bts_pkg::*;

  logic [2:0] pending_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  // At most two items are held: input register and result register
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd2)
    else $error("more items held than the two registers allow");

  // No result without an item in flight
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 3'd0)
    else $error("result shown with no item outstanding");

  // A finished note cannot still be busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.note_done |-> !out_data_i.busy_res)
    else $error("note_done with busy_res set");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");
endmodule

bind buzzer_tone_sequencer bts_checker u_bts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the buzzer tone sequencer: predictor, random idling, field checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bts_pkg::*;

  // Command code that the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYC = 8;      // wait after the last result before the next test
  localparam int IDLE_LIMIT = 1000;   // cycles with nothing accepted before giving up
  localparam int TONE_ROWS  = 37;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bts_stream_if #(.T(in_item_t))  in_if  ();
  bts_stream_if #(.T(out_item_t)) out_if ();
  bts_stream_if #(.T(cfg_wr_t))   cfg_if ();

  buzzer_tone_sequencer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Reload values per note, entry 0 is a rest
  logic [15:0] reload_tab [TONE_ROWS] = '{
    16'd0,     16'd63628, 16'd63731, 16'd63835, 16'd63928, 16'd64021, 16'd64103,
    16'd64185, 16'd64260, 16'd64331, 16'd64400, 16'd64463, 16'd64528, 16'd64580,
    16'd64633, 16'd64684, 16'd64732, 16'd64777, 16'd64820, 16'd64860, 16'd64898,
    16'd64934, 16'd64968, 16'd65000, 16'd65030, 16'd65058, 16'd65085, 16'd65110,
    16'd65134, 16'd65157, 16'd65178, 16'd65198, 16'd65217, 16'd65235, 16'd65252,
    16'd65268, 16'd65283
  };

  // Predicted state of the block and its registers
  logic [15:0] tone_cnt  = '0;
  logic        buzz      = 1'b1;
  logic [5:0]  cur_note  = '0;
  logic [15:0] prescale  = '0;
  logic [17:0] ms_left   = '0;
  phase_e      phase     = PH_IDLE;
  logic [9:0]  cfg_mps   = MS_PER_SIXTEENTH_RST;
  logic [15:0] cfg_tpm   = TICKS_PER_MS_RST;
  logic [7:0]  cfg_gap   = GAP_MS_RST;

  out_item_t   levels_q [$];   // expected levels, oldest first
  int          n_err     = 0;
  int          n_items   = 0;
  int          n_levels  = 0;
  int          n_toggles = 0;
  int          n_done    = 0;
  int          n_writes  = 0;
  logic        last_buzz = 1'b1;
  int          burst_left = 0;
  int          rcv_cyc   = 0;
  int          stall_cyc = 0;

  // Advance the tone and note timers by one item and return the levels it gives
  function automatic out_item_t tone_step(input in_item_t it);
    out_item_t   res;
    logic [15:0] rl;
    logic [31:0] prod;
    logic        done;
    done = 1'b0;
    case (it.command)
      CMD_TICK: begin
        // tone counter runs on the phase held at the start of the tick
        if (phase == PH_IDLE || phase == PH_NOTE) begin
          if (tone_cnt == 16'hFFFF) begin
            rl = (cur_note < TONE_ROWS) ? reload_tab[cur_note] : 16'd0;
            if (rl != 16'd0) begin
              tone_cnt = rl;
              buzz     = ~buzz;
            end else begin
              tone_cnt = '0;
            end
          end else begin
            tone_cnt = tone_cnt + 16'd1;
          end
        end
        // note and gap timing
        if (phase == PH_NOTE || phase == PH_GAP) begin
          if (ms_left != 0) begin
            prescale = prescale + 16'd1;
            if (prescale >= cfg_tpm) begin
              prescale = '0;
              ms_left  = ms_left - 18'd1;
            end
          end
          if (ms_left == 0) begin
            prescale = '0;
            if (phase == PH_NOTE) begin
              phase   = PH_GAP;
              ms_left = 18'(cfg_gap);
            end else begin
              phase = PH_IDLE;
              done  = 1'b1;
            end
          end
        end
      end
      CMD_NOTE: begin
        prod     = 32'(it.note_length) * 32'(cfg_mps);
        cur_note = it.note_index;
        ms_left  = prod[17:0];
        prescale = '0;
        phase    = PH_NOTE;
      end
      CMD_STOP: begin
        phase    = PH_STOP;
        ms_left  = '0;
        prescale = '0;
      end
      default: ;
    endcase
    res.buzzer_level = buzz;
    res.busy_res     = (phase == PH_NOTE || phase == PH_GAP);
    res.note_done    = done;
    return res;
  endfunction

  function automatic in_item_t mk_item(input logic [1:0] c, input logic [5:0] idx,
                                       input logic [7:0] len);
    in_item_t it;
    it.command     = c;
    it.note_index  = idx;
    it.note_length = len;
    return it;
  endfunction

  task automatic report_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
    end
  endtask

  // Register writes, results and new items, all sampled at the clock edge
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        n_writes++;
        case (cfg_if.data.index)
          REG_MS_PER_SIXTEENTH: cfg_mps = cfg_if.data.wdata[9:0];
          REG_TICKS_PER_MS:     cfg_tpm = cfg_if.data.wdata;
          REG_GAP_MS:           cfg_gap = cfg_if.data.wdata[7:0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        if (levels_q.size() == 0) begin
          n_err++;
          $display("%0t: result with none expected, got %b", $time, out_if.data);
        end else begin
          want = levels_q.pop_front();
          n_levels++;
          report_field("buzzer_level", want.buzzer_level, out_if.data.buzzer_level);
          report_field("busy_res", want.busy_res, out_if.data.busy_res);
          report_field("note_done", want.note_done, out_if.data.note_done);
        end
      end
      if (in_if.valid && in_if.ready) begin
        want = tone_step(in_if.data);
        if (want.buzzer_level != last_buzz) n_toggles++;
        last_buzz = want.buzzer_level;
        if (want.note_done) n_done++;
        levels_q.push_back(want);
        n_items++;
      end
    end
  end

  // Receiver stalls: steady, sparse random, periodic and heavy random stretches
  always @(posedge clk_i) begin
    rcv_cyc <= rcv_cyc + 1;
    case (rcv_cyc[10:9])
      2'd0:    out_if.ready <= 1'b1;
      2'd1:    out_if.ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_if.ready <= (rcv_cyc % 5 != 0);
      default: out_if.ready <= 1'($urandom_range(0, 1));
    endcase
  end

  // Watchdog on cycles where no channel moves
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stall_cyc <= 0;
      end else if (stall_cyc >= IDLE_LIMIT) begin
        $display("%0t: nothing accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        stall_cyc <= stall_cyc + 1;
      end
    end
  end

  // Send one item; the sender works in bursts with random gaps between them
  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Hold the sender until every expected result has come, then let the block settle
  task automatic wait_levels_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (levels_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Write all three registers back to back
  task automatic set_tempo(input logic [15:0] mps, input logic [15:0] tpm,
                           input logic [15:0] gap);
    cfg_wr_t wr [3];
    wr[0] = '{index: REG_MS_PER_SIXTEENTH, wdata: mps};
    wr[1] = '{index: REG_TICKS_PER_MS,     wdata: tpm};
    wr[2] = '{index: REG_GAP_MS,           wdata: gap};
    foreach (wr[i]) begin
      cfg_if.valid <= 1'b1;
      cfg_if.data  <= wr[i];
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Every command, field extremes, zero durations, zero tick rate, restarts, rests
  task automatic test_corner_commands();
    in_item_t seq [$];
    set_tempo(16'd1, 16'd0, 16'd0);
    seq = '{
      mk_item(CMD_TICK, 6'd0, 8'd0),
      mk_item(CMD_UNUSED, 6'd63, 8'd255),
      mk_item(CMD_STOP, 6'd0, 8'd0),
      mk_item(CMD_TICK, 6'd0, 8'd0),
      mk_item(CMD_NOTE, 6'd36, 8'd0),
      mk_item(CMD_TICK, 6'd0, 8'd0),
      mk_item(CMD_TICK, 6'd0, 8'd0),
      mk_item(CMD_TICK, 6'd0, 8'd0),
      mk_item(CMD_NOTE, 6'd63, 8'd255),
      mk_item(CMD_TICK, 6'd0, 8'd0),
      mk_item(CMD_TICK, 6'd0, 8'd0),
      mk_item(CMD_NOTE, 6'd1, 8'd1),
      mk_item(CMD_TICK, 6'd0, 8'd0),
      mk_item(CMD_TICK, 6'd0, 8'd0),
      mk_item(CMD_TICK, 6'd0, 8'd0),
      mk_item(CMD_STOP, 6'd0, 8'd0),
      mk_item(CMD_TICK, 6'd0, 8'd0),
      mk_item(CMD_NOTE, 6'd37, 8'd2),
      mk_item(CMD_STOP, 6'd0, 8'd0),
      mk_item(CMD_UNUSED, 6'd0, 8'd0),
      mk_item(CMD_NOTE, 6'd0, 8'd0),
      mk_item(CMD_TICK, 6'd0, 8'd0),
      mk_item(CMD_TICK, 6'd0, 8'd0),
      mk_item(CMD_TICK, 6'd0, 8'd0)
    };
    foreach (seq[i]) send_item(seq[i]);
    wait_levels_drained();
  endtask

  // Long notes at the slowest tempo, restarted mid-note, then a stop that halts the counter
  task automatic test_long_note();
    set_tempo(16'd1023, 16'd65535, 16'd255);
    send_item(mk_item(CMD_NOTE, 6'd36, 8'd255));
    repeat (40) send_item(mk_item(CMD_TICK, 6'd0, 8'd0));
    send_item(mk_item(CMD_NOTE, 6'd1, 8'd255));
    repeat (30) send_item(mk_item(CMD_TICK, 6'd0, 8'd0));
    // halted counter must hold
    send_item(mk_item(CMD_STOP, 6'd0, 8'd0));
    repeat (15) send_item(mk_item(CMD_TICK, 6'd0, 8'd0));
    wait_levels_drained();
  endtask

  // Notes followed by runs of ticks, with stops and noise mixed in
  task automatic test_random_traffic(input logic [15:0] mps, input logic [15:0] tpm,
                                     input logic [15:0] gap, input int target,
                                     input int max_run, input int max_len);
    int       n_sent;
    int       run;
    int       n_noise;
    bit       paused;
    in_item_t it;
    n_sent = 0;
    paused = 1'b0;
    set_tempo(mps, tpm, gap);
    while (n_sent < target) begin
      if ($urandom_range(0, 4) != 0) begin
        it.command     = CMD_NOTE;
        it.note_index  = ($urandom_range(0, 15) == 0) ? 6'($urandom_range(0, 63))
                                                      : 6'($urandom_range(1, 36));
        it.note_length = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, max_len));
        send_item(it);
        run = $urandom_range(1, max_run);
        repeat (run) send_item(mk_item(CMD_TICK, 6'($urandom), 8'($urandom)));
        n_sent += run + 1;
        if ($urandom_range(0, 9) == 0) begin
          send_item(mk_item(CMD_STOP, 6'($urandom), 8'($urandom)));
          n_sent++;
        end
      end else begin
        n_noise = $urandom_range(1, 4);
        repeat (n_noise) begin
          it = in_item_t'($urandom);
          send_item(it);
          if (it.command != CMD_UNUSED) n_sent++;
        end
      end
      // one pause in the middle with nothing left outstanding
      if (!paused && n_sent >= target / 2) begin
        wait_levels_drained();
        paused = 1'b1;
      end
    end
    wait_levels_drained();
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    out_if.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_corner_commands();
    test_long_note();
    test_random_traffic(16'd1, 16'd1, 16'd0, 100, 40, 6);
    test_random_traffic(16'd3, 16'd2, 16'd2, 100, 40, 6);
    test_random_traffic(16'd1023, 16'd1, 16'd255, 100, 120, 1);
    test_random_traffic(16'($urandom_range(1, 8)), 16'($urandom_range(1, 4)),
                        16'($urandom_range(0, 7)), 100, 60, 8);

    $display("Covered %0d items, %0d results checked, %0d register writes;",
             n_items, n_levels, n_writes);
    $display("buzzer toggled %0d times, %0d note-done pulses, %0d errors.",
             n_toggles, n_done, n_err);
    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bts_pkg.sv
rtl/bts_stream_if.sv
rtl/bts_cfg_regs.sv
rtl/bts_tone_core.sv
rtl/buzzer_tone_sequencer.sv
rtl/bts_checker.sv
test/tb_top.sv
